// ===== hdl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// shared types for the heap sorter: word formats, controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package hs_pkg;

  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      last_element;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_result;
    logic                      overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_RD,
    ST_EXT_LD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // commands from controller to datapath, at most one set per cycle
  typedef struct packed {
    logic collect;     // input word accepted
    logic build_rd;    // fetch next heap node to sift during build
    logic build_ld;    // start sift of fetched node over whole heap
    logic ext_rd;      // fetch root and last heap entry
    logic ext_ld;      // move root to end, start sift of old last entry
    logic sift_rd;     // fetch both children of the hole
    logic sift_place;  // hole is a leaf, drop held value there
    logic sift_cmp;    // compare children with held value
    logic emit_rd;     // fetch next sorted entry
    logic emit_ld;     // load output register
  } cmd_t;

  typedef struct packed {
    logic build_done;  // no interior nodes left to sift
    logic ext_done;    // heap down to one entry
    logic sift_leaf;   // hole has no children
    logic sift_stop;   // held value not smaller than larger child
    logic emit_last;   // entry being emitted is the final one
    logic out_free;    // output register empty by next edge
  } stat_t;

endpackage

// ===== hdl/hs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hs_ctrl
// sequencer for collect, heap build, extraction and emit phases
// ----------------------------------------------------------------------------
module hs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic          item_last,
  output logic          item_ready,
  input  hs_pkg::stat_t stat,
  output hs_pkg::cmd_t  cmd
);

  hs_pkg::state_t state, state_next;
  logic           phase_ext, phase_ext_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hs_pkg::ST_IDLE;
      phase_ext <= 1'b0;
    end else begin
      state     <= state_next;
      phase_ext <= phase_ext_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    phase_ext_next = phase_ext;
    unique case (state)
      hs_pkg::ST_IDLE: begin
        if (item_valid && item_last) state_next = hs_pkg::ST_BUILD_RD;
      end
      hs_pkg::ST_BUILD_RD: begin
        state_next = stat.build_done ? hs_pkg::ST_EXT_RD : hs_pkg::ST_BUILD_LD;
      end
      hs_pkg::ST_BUILD_LD: begin
        state_next     = hs_pkg::ST_SIFT_RD;
        phase_ext_next = 1'b0;
      end
      hs_pkg::ST_SIFT_RD: begin
        if (stat.sift_leaf) begin
          state_next = phase_ext ? hs_pkg::ST_EXT_RD : hs_pkg::ST_BUILD_RD;
        end else begin
          state_next = hs_pkg::ST_SIFT_CMP;
        end
      end
      hs_pkg::ST_SIFT_CMP: begin
        if (stat.sift_stop) begin
          state_next = phase_ext ? hs_pkg::ST_EXT_RD : hs_pkg::ST_BUILD_RD;
        end else begin
          state_next = hs_pkg::ST_SIFT_RD;
        end
      end
      hs_pkg::ST_EXT_RD: begin
        state_next = stat.ext_done ? hs_pkg::ST_EMIT_RD : hs_pkg::ST_EXT_LD;
      end
      hs_pkg::ST_EXT_LD: begin
        state_next     = hs_pkg::ST_SIFT_RD;
        phase_ext_next = 1'b1;
      end
      hs_pkg::ST_EMIT_RD: begin
        if (stat.out_free) state_next = hs_pkg::ST_EMIT_LD;
      end
      hs_pkg::ST_EMIT_LD: begin
        state_next = stat.emit_last ? hs_pkg::ST_IDLE : hs_pkg::ST_EMIT_RD;
      end
      default: state_next = hs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      hs_pkg::ST_IDLE: begin
        item_ready  = 1'b1;
        cmd.collect = item_valid;
      end
      hs_pkg::ST_BUILD_RD: cmd.build_rd = !stat.build_done;
      hs_pkg::ST_BUILD_LD: cmd.build_ld = 1'b1;
      hs_pkg::ST_SIFT_RD: begin
        cmd.sift_place = stat.sift_leaf;
        cmd.sift_rd    = !stat.sift_leaf;
      end
      hs_pkg::ST_SIFT_CMP: cmd.sift_cmp = 1'b1;
      hs_pkg::ST_EXT_RD:   cmd.ext_rd   = !stat.ext_done;
      hs_pkg::ST_EXT_LD:   cmd.ext_ld   = 1'b1;
      hs_pkg::ST_EMIT_RD:  cmd.emit_rd  = stat.out_free;
      hs_pkg::ST_EMIT_LD:  cmd.emit_ld  = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/hs_dp.sv =====
// ----------------------------------------------------------------------------
// hs_dp
// value memory, heap indexes, sift compare and output register
// ----------------------------------------------------------------------------
module hs_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  hs_pkg::cmd_t    cmd,
  output hs_pkg::stat_t   stat,
  input  hs_pkg::item_t   item,
  output hs_pkg::result_t result,
  output logic            result_valid,
  input  logic            result_ready
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = AW + 2;

  logic signed [hs_pkg::VALUE_W-1:0] mem [MAX_ITEMS];

  logic [CW-1:0] count, count_next;
  logic          ovf;
  logic [AW-1:0] bi;
  logic [CW-1:0] s;
  logic [AW-1:0] k;
  logic [AW-1:0] node;
  logic [CW-1:0] size;
  logic          right_ok;
  logic signed [hs_pkg::VALUE_W-1:0] cur;
  logic signed [hs_pkg::VALUE_W-1:0] rd_a, rd_b;

  logic          room;
  logic [IW-1:0] left, right, size_ext;
  logic          take_right, descend;
  logic signed [hs_pkg::VALUE_W-1:0] big_val;
  logic [AW-1:0] big_idx;
  logic [CW-1:0] s_dec;

  logic          we, rd_en;
  logic [AW-1:0] waddr, ra, rb;
  logic signed [hs_pkg::VALUE_W-1:0] wdata;

  assign room       = count < CW'(MAX_ITEMS);
  assign count_next = room ? count + CW'(1) : count;
  assign s_dec      = s - CW'(1);
  assign left       = IW'({node, 1'b1});
  assign right      = left + IW'(1);
  assign size_ext   = IW'(size);

  // larger child, then whether it beats the held value
  assign take_right = right_ok && (rd_b > rd_a);
  assign big_val    = take_right ? rd_b : rd_a;
  assign big_idx    = take_right ? right[AW-1:0] : left[AW-1:0];
  assign descend    = big_val > cur;

  assign stat.build_done = (bi == '0);
  assign stat.ext_done   = (s <= CW'(1));
  assign stat.sift_leaf  = (left >= size_ext);
  assign stat.sift_stop  = !descend;
  assign stat.emit_last  = (CW'(k) + CW'(1) == count);
  assign stat.out_free   = !result_valid || result_ready;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = cur;
    if (cmd.collect && room) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = item.element;
    end else if (cmd.ext_ld) begin
      we    = 1'b1;
      waddr = s_dec[AW-1:0];
      wdata = rd_a;
    end else if (cmd.sift_place) begin
      we    = 1'b1;
    end else if (cmd.sift_cmp) begin
      we    = 1'b1;
      wdata = descend ? big_val : cur;
    end
  end

  always_comb begin
    rd_en = cmd.build_rd || cmd.ext_rd || cmd.sift_rd || cmd.emit_rd;
    ra    = k;
    rb    = right[AW-1:0];
    if (cmd.build_rd) begin
      ra = bi - AW'(1);
    end else if (cmd.ext_rd) begin
      ra = '0;
      rb = s_dec[AW-1:0];
    end else if (cmd.sift_rd) begin
      ra = left[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

  // heap bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.collect && item.last_element) begin
      bi <= AW'(count_next >> 1);
      s  <= count_next;
    end
    if (cmd.build_rd) bi <= bi - AW'(1);
    if (cmd.build_ld) begin
      cur  <= rd_a;
      node <= bi;
      size <= count;
    end
    if (cmd.ext_ld) begin
      cur  <= rd_b;
      node <= '0;
      size <= s_dec;
      s    <= s_dec;
    end
    if (cmd.sift_rd) right_ok <= (right < size_ext);
    if (cmd.sift_cmp && descend) node <= big_idx;
    if (cmd.emit_ld) begin
      result.sorted_value <= rd_a;
      result.last_result  <= stat.emit_last;
      result.overflow     <= ovf;
    end
  end

  // run counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.collect) begin
        count <= count_next;
        if (!room) ovf <= 1'b1;
      end
      if (cmd.emit_ld) begin
        if (stat.emit_last) begin
          k     <= '0;
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          k <= k + AW'(1);
        end
      end
      if (cmd.emit_ld) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/heap_sorter.sv =====
// operation: a run of n words is collected word by word, then the heap is built and
//   the root extracted repeatedly, each sift level a read state and a compare state,
//   and each result word is fetched and then loaded into the output register
// the whole run goes through the single sift unit on the memory; no new set is
//   accepted until the final word of the last one sits in the output register
// reset: synchronous, clears the fill count, overflow flag and sequencer
// ----------------------------------------------------------------------------
// heap_sorter
// collects signed words until one marked last, heap sorts them in an on-chip
// memory and emits them in ascending order with end and overflow marks
// ----------------------------------------------------------------------------
module heap_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  hs_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_ready,
  output hs_pkg::result_t result
);

  // controller drives one command set per cycle, datapath reports status
  hs_pkg::cmd_t  cmd;
  hs_pkg::stat_t stat;

  // sequencer: collect, build heap, extract root repeatedly, emit
  hs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last_element),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // memory with two registered read ports and one write port, sift compare,
  // output register that frees the collect side while the final word waits
  hs_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ===== verif/heap_sorter_tb.sv =====
// ----------------------------------------------------------------------------
// heap_sorter_tb
// self-checking bench for the heap sorter: feeds sets of signed words, each
// closed by a last mark, predicts the ascending output with end and overflow
// marks, and checks every emitted word against the oldest prediction while
// both handshakes idle and stall at random
// ----------------------------------------------------------------------------
typedef logic signed [hs_pkg::VALUE_W-1:0] value_t;

class sort_scoreboard;
  hs_pkg::result_t sorted_q[$];
  value_t          held_q[$];
  bit              dropped;
  int              cap;
  int              errors;
  int              words_in;
  int              words_out;
  int              sets_done;
  int              overflow_sets;

  function new(int depth);
    cap = depth;
  endfunction

  task report(string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  // store the value if there is room; a last word closes the set
  function void note_item(hs_pkg::item_t it);
    value_t          v;
    hs_pkg::result_t r;
    int              j;
    words_in++;
    if (held_q.size() < cap) held_q.push_back(it.element);
    else dropped = 1'b1;
    if (!it.last_element) return;
    for (int i = 1; i < held_q.size(); i++) begin
      v = held_q[i];
      j = i - 1;
      while (j >= 0 && held_q[j] > v) begin
        held_q[j+1] = held_q[j];
        j--;
      end
      held_q[j+1] = v;
    end
    for (int k = 0; k < held_q.size(); k++) begin
      r.sorted_value = held_q[k];
      r.last_result  = (k == held_q.size() - 1);
      r.overflow     = dropped;
      sorted_q.push_back(r);
    end
    sets_done++;
    if (dropped) overflow_sets++;
    held_q.delete();
    dropped = 1'b0;
  endfunction

  task check_result(hs_pkg::result_t r);
    hs_pkg::result_t e;
    words_out++;
    if (sorted_q.size() == 0) begin
      report($sformatf("word %0d emitted with nothing pending", r.sorted_value));
      return;
    end
    e = sorted_q.pop_front();
    if (r.sorted_value !== e.sorted_value)
      report($sformatf("sorted_value %0d, wanted %0d", r.sorted_value, e.sorted_value));
    if (r.last_result !== e.last_result)
      report($sformatf("last_result %b, wanted %b at value %0d",
                       r.last_result, e.last_result, e.sorted_value));
    if (r.overflow !== e.overflow)
      report($sformatf("overflow %b, wanted %b at value %0d",
                       r.overflow, e.overflow, e.sorted_value));
  endtask
endclass

module heap_sorter_tb;

  localparam int CAP       = 64;
  localparam int LIMIT     = 200000;   // cycles, far beyond the slowest run
  localparam int HOLD_LEN  = 300;      // long receiver hold-off
  localparam int DRAIN     = 200;      // quiet cycles after the last word

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            item_valid   = 1'b0;
  logic            item_ready;
  hs_pkg::item_t   item         = '0;
  logic            result_valid;
  logic            result_ready = 1'b0;
  hs_pkg::result_t result;

  sort_scoreboard sb;

  // idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int     cycle_count = 0;
  int     phase_items;
  int     n;
  value_t dir_q[$];

  heap_sorter #(.MAX_ITEMS(CAP)) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // mix of extremes, a narrow band that gives duplicates, and full-range noise
  function automatic value_t rand_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return value_t'($urandom_range(15)) - 8;
      default: return value_t'($urandom);
    endcase
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_item(input value_t v, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      item       <= hs_pkg::item_t'({$urandom, 1'($urandom)});  // junk while idle
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= hs_pkg::item_t'({v, is_last});
    do @(posedge clk); while (!item_ready);
  endtask

  // one random set of n words, the final one marked last
  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_item(rand_value(), i == len - 1);
  endtask

  // send the directed queue as one set, then clear it
  task automatic send_directed();
    for (int i = 0; i < dir_q.size(); i++) send_item(dir_q[i], i == dir_q.size() - 1);
    dir_q.delete();
  endtask

  // input monitor: every accepted word feeds the predictor
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_item(item);
  end

  // output monitor: every accepted word is checked in order
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // receiver: random stalls, plus a long counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sb = new(CAP);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
        end
      endcase

      if (ph == 0) begin
        // single word set
        dir_q = '{32'sd0};
        send_directed();
        // two words, reversed
        dir_q = '{32'sd2, 32'sd1};
        send_directed();
        // both extremes and the values around zero
        dir_q = '{32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1,
                  32'sh8000_0001};
        send_directed();
        // equal values side by side
        dir_q = '{32'sd5, 32'sd5, -32'sd5, 32'sd5, -32'sd5};
        send_directed();
        // already ascending
        dir_q = '{-32'sd3, -32'sd2, 32'sd7, 32'sd100};
        send_directed();
        // strictly descending
        dir_q = '{32'sd100, 32'sd7, -32'sd2, -32'sd3};
        send_directed();
        // long receiver hold-off while sets keep coming, so input backs up
        hold_req = 1'b1;
      end

      // full store with the last word dropped
      if (ph == 2) send_run(CAP + 1);
      // words dropped before the last one as well
      if (ph == 3) send_run(CAP + 3);

      phase_items = 0;
      while (phase_items < 15) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        send_run(n);
        phase_items += n;
      end
    end
    item_valid <= 1'b0;

    // let every predicted word come out, then watch for strays
    while (sb.sorted_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d sets (%0d with dropped words), %0d words in, %0d words out",
             sb.sets_done, sb.overflow_sets, sb.words_in, sb.words_out);
    $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
    if (sb.errors == 0 && sb.sorted_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hs_pkg.sv
hdl/hs_ctrl.sv
hdl/hs_dp.sv
hdl/heap_sorter.sv
verif/heap_sorter_tb.sv
